FILE: design/gri_pkg.sv
// ----------------------------------------------------------------------------
// gri_pkg: shared types and constants for the gyro rate bias integrator
// Field widths, register reset values, command and status codes, and the
// sizes of the bit-serial multiplier and divider.
// ----------------------------------------------------------------------------
package gri_pkg;

  // Width of the calibration sample counter.
  localparam int CNT_W = 24;

  localparam int RAW_W   = 16;
  localparam int BIAS_W  = 24;
  localparam int RATE_W  = 32;
  localparam int ANGLE_W = 48;
  localparam int DB_W    = 31;
  localparam int CFG_W   = 32;

  localparam logic [CFG_W-1:0] RATE_SCALE_RST = 32'd937016;
  localparam logic [DB_W-1:0]  DEAD_BAND_RST  = 31'd0;
  localparam logic [CFG_W-1:0] STEP_TIME_RST  = 32'd8676701;

  localparam logic [1:0] CFG_RATE_SCALE = 2'd0;
  localparam logic [1:0] CFG_DEAD_BAND  = 2'd1;
  localparam logic [1:0] CFG_STEP_TIME  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_DEVICE = 2'd1;
  localparam logic [1:0] STATUS_LINK   = 2'd2;

  typedef enum logic [2:0] {
    FUNC_SAMPLE    = 3'd0,
    FUNC_CAL_START = 3'd1,
    FUNC_CAL_STOP  = 3'd2,
    FUNC_SET_ANGLE = 3'd3,
    FUNC_SET_BIAS  = 3'd4
  } gri_func_t;

  // Serial multiplier: signed multiplicand times unsigned 32-bit multiplier.
  localparam int MUL_A_W     = 33;
  localparam int MUL_B_W     = 32;
  localparam int MUL_STEPS   = MUL_B_W;
  localparam int MUL_HI_W    = MUL_A_W + 1;
  localparam int MUL_P_W     = MUL_HI_W + MUL_B_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS + 1);

  // Running mean: signed numerator, its magnitude, and the restoring divider.
  localparam int SNUM_W      = CNT_W + BIAS_W + 1;
  localparam int NUM_W       = CNT_W + BIAS_W;
  localparam int DEN_W       = CNT_W + 1;
  localparam int REM_W       = CNT_W + 2;
  localparam int DIV_STEPS   = BIAS_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAL_GO,
    ST_CAL_MUL,
    ST_CAL_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CAL_BIAS,
    ST_RATE_GO,
    ST_RATE_MUL,
    ST_RATE_SAT,
    ST_DEAD,
    ST_ANG_GO,
    ST_ANG_MUL,
    ST_ANG_ADD,
    ST_PUSH
  } gri_state_t;

endpackage

FILE: design/gri_mul.sv
// ----------------------------------------------------------------------------
// gri_mul: bit-serial shift-add multiplier
// Multiplies a signed multiplicand by an unsigned multiplier, one multiplier
// bit per cycle, with the partial product shifted right through a register.
// ----------------------------------------------------------------------------
module gri_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [gri_pkg::MUL_A_W-1:0]  a,
  input  logic        [gri_pkg::MUL_B_W-1:0]  b,
  output logic                                busy,
  output logic signed [gri_pkg::MUL_P_W-1:0]  product
);
  import gri_pkg::*;

  logic signed [MUL_A_W-1:0]   a_r;
  logic signed [MUL_HI_W-1:0]  hi_r;
  logic        [MUL_B_W-1:0]   lo_r;
  logic        [MUL_CNT_W-1:0] cnt_r;
  logic signed [MUL_HI_W-1:0]  sum;

  assign sum     = hi_r + (lo_r[0] ? {a_r[MUL_A_W-1], a_r} : '0);
  assign busy    = (cnt_r != '0);
  assign product = {hi_r, lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= MUL_CNT_W'(MUL_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy) begin
      hi_r <= {sum[MUL_HI_W-1], sum[MUL_HI_W-1:1]};
      lo_r <= {sum[0], lo_r[MUL_B_W-1:1]};
    end
  end

endmodule

FILE: design/gri_div.sv
// ----------------------------------------------------------------------------
// gri_div: bit-serial restoring divider
// Divides an unsigned numerator by an unsigned divisor, one quotient bit per
// cycle. The quotient is known to fit the bias width.
// ----------------------------------------------------------------------------
module gri_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [gri_pkg::NUM_W-1:0]         num,
  input  logic [gri_pkg::DEN_W-1:0]         den,
  output logic                              busy,
  output logic [gri_pkg::BIAS_W-1:0]        quo
);
  import gri_pkg::*;

  logic [REM_W-1:0]     r_r;
  logic [BIAS_W-1:0]    q_r;
  logic [DEN_W-1:0]     den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [REM_W-1:0]     trial;
  logic                 fits;

  assign trial = {r_r[REM_W-2:0], q_r[BIAS_W-1]};
  assign fits  = (trial >= REM_W'(den_r));
  assign busy  = (cnt_r != '0);
  assign quo   = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r   <= REM_W'(num[NUM_W-1:BIAS_W]);
      q_r   <= num[BIAS_W-1:0];
      den_r <= den;
    end else if (busy) begin
      r_r <= fits ? (trial - REM_W'(den_r)) : trial;
      q_r <= {q_r[BIAS_W-2:0], fits};
    end
  end

endmodule

FILE: design/gyro_rate_bias_integrator.sv
// ----------------------------------------------------------------------------
// gyro_rate_bias_integrator: gyro bias calibration and rate integration
// Takes sensor samples and commands, keeps the bias estimate, the scaled
// rate and the integrated angle, and reports the state after every request.
//
// Input requests carry a function code with a sensor word, a link error flag,
// an angle and a bias value. Each request yields exactly one result request
// on the output channel. Configuration registers are written over the cfg_
// port, which is always ready. The user must write them only while the block
// is idle; the block itself does not enforce this.
// A command or a rejected calibration sample goes straight to the output
// stage. A sample out of calibration takes two passes of the 32-step serial
// multiplier; a good calibration sample takes a 32-step multiply, the 24-step
// serial divider and the 32-step scaling multiply.
// One request is processed at a time; the next one is taken in the cycle after
// the result has moved into the output register, even if it waits there.
// A stalled output holds its result; a further finished result then waits
// and the input stalls. Reset enters calibration mode with the sample, bias,
// count, rates and angle zero and the configuration at its reset values.
// ----------------------------------------------------------------------------
module gyro_rate_bias_integrator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [2:0]                           in_func,
  input  logic [31:0]                          in_response_word,
  input  logic                                 in_link_error,
  input  logic signed [gri_pkg::ANGLE_W-1:0]   in_angle_value,
  input  logic signed [gri_pkg::BIAS_W-1:0]    in_bias_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gri_pkg::RAW_W-1:0]     out_raw_rate,
  output logic signed [gri_pkg::RATE_W-1:0]    out_rate,
  output logic signed [gri_pkg::RATE_W-1:0]    out_clean_rate,
  output logic signed [gri_pkg::ANGLE_W-1:0]   out_angle,
  output logic signed [gri_pkg::BIAS_W-1:0]    out_bias,
  output logic [1:0]                           out_status,
  output logic                                 out_calibrating,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [gri_pkg::CFG_W-1:0]            cfg_data
);
  import gri_pkg::*;

  gri_state_t state_r, state_nxt;

  logic [CFG_W-1:0] rate_scale_r;
  logic [DB_W-1:0]  dead_band_r;
  logic [CFG_W-1:0] step_time_r;

  logic signed [RAW_W-1:0]   raw_hold_r, raw_hold_nxt;
  logic signed [BIAS_W-1:0]  bias_hold_r, bias_hold_nxt;
  logic [CNT_W-1:0]          calib_count_r, calib_count_nxt;
  logic                      calib_mode_r, calib_mode_nxt;
  logic [ANGLE_W-1:0]        angle_accum_r, angle_accum_nxt;
  logic signed [RATE_W-1:0]  rate_hold_r, rate_hold_nxt;
  logic signed [RATE_W-1:0]  clean_hold_r, clean_hold_nxt;
  logic [1:0]                status_r, status_nxt;
  logic signed [SNUM_W-1:0]  num_r, num_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_load;

  logic signed [RAW_W-1:0]   out_raw_rate_r;
  logic signed [RATE_W-1:0]  out_rate_r;
  logic signed [RATE_W-1:0]  out_clean_rate_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  logic signed [BIAS_W-1:0]  out_bias_r;
  logic [1:0]                out_status_r;
  logic                      out_calibrating_r;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_busy;
  logic signed [MUL_P_W-1:0] mul_prod;

  logic                      div_start;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic                      div_busy;
  logic [BIAS_W-1:0]         div_quo;

  logic                      in_accept;
  logic [1:0]                sample_status;
  logic signed [BIAS_W:0]    diff;
  logic signed [SNUM_W-1:0]  num_mag;
  logic [RATE_W-1:0]         rate_abs;
  logic                      sat_over;

  gri_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  gri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_link_error || (in_response_word[31:29] != 3'b000)) begin
      sample_status = STATUS_LINK;
    end else if ((in_response_word[27:26] == 2'b01) && !in_response_word[2]) begin
      sample_status = STATUS_OK;
    end else begin
      sample_status = STATUS_DEVICE;
    end
  end

  assign diff     = {raw_hold_r[RAW_W-1], raw_hold_r, 8'h00}
                  - {bias_hold_r[BIAS_W-1], bias_hold_r};
  assign num_mag  = num_r[SNUM_W-1] ? -num_r : num_r;
  assign rate_abs = rate_hold_r[RATE_W-1] ? (RATE_W'(0) - rate_hold_r) : rate_hold_r;
  assign sat_over = (mul_prod[MUL_P_W-1:55] != '0) && (mul_prod[MUL_P_W-1:55] != '1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    raw_hold_nxt    = raw_hold_r;
    bias_hold_nxt   = bias_hold_r;
    calib_count_nxt = calib_count_r;
    calib_mode_nxt  = calib_mode_r;
    angle_accum_nxt = angle_accum_r;
    rate_hold_nxt   = rate_hold_r;
    clean_hold_nxt  = clean_hold_r;
    status_nxt      = status_r;
    num_nxt         = num_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_load        = 1'b0;
    mul_start       = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    div_start       = 1'b0;
    div_num         = num_mag[NUM_W-1:0];
    div_den         = {1'b0, calib_count_r} + 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          status_nxt = STATUS_OK;
          state_nxt  = ST_PUSH;
          case (in_func)
            FUNC_SAMPLE: begin
              status_nxt = sample_status;
              if (sample_status == STATUS_OK) begin
                raw_hold_nxt = in_response_word[25:10];
              end
              if (!calib_mode_r) begin
                state_nxt = ST_RATE_GO;
              end else if (sample_status == STATUS_OK) begin
                state_nxt = ST_CAL_GO;
              end
            end
            FUNC_CAL_START: begin
              calib_mode_nxt  = 1'b1;
              calib_count_nxt = '0;
              bias_hold_nxt   = '0;
            end
            FUNC_CAL_STOP: begin
              calib_mode_nxt = 1'b0;
            end
            FUNC_SET_ANGLE: begin
              angle_accum_nxt = in_angle_value;
            end
            FUNC_SET_BIAS: begin
              bias_hold_nxt = in_bias_value;
            end
            default: begin
              state_nxt = ST_PUSH;
            end
          endcase
        end
      end
      ST_CAL_GO: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-BIAS_W){bias_hold_r[BIAS_W-1]}}, bias_hold_r};
        mul_b     = MUL_B_W'(calib_count_r);
        state_nxt = ST_CAL_MUL;
      end
      ST_CAL_MUL: begin
        if (!mul_busy) begin
          state_nxt = ST_CAL_SUM;
        end
      end
      ST_CAL_SUM: begin
        num_nxt   = mul_prod[SNUM_W-1:0]
                  + {{(SNUM_W-RAW_W-8){raw_hold_r[RAW_W-1]}}, raw_hold_r, 8'h00};
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_nxt = ST_CAL_BIAS;
        end
      end
      ST_CAL_BIAS: begin
        bias_hold_nxt = num_r[SNUM_W-1] ? -div_quo : div_quo;
        state_nxt     = ST_RATE_GO;
      end
      ST_RATE_GO: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-BIAS_W-1){diff[BIAS_W]}}, diff};
        mul_b     = rate_scale_r;
        state_nxt = ST_RATE_MUL;
      end
      ST_RATE_MUL: begin
        if (!mul_busy) begin
          state_nxt = ST_RATE_SAT;
        end
      end
      ST_RATE_SAT: begin
        if (sat_over) begin
          rate_hold_nxt = mul_prod[MUL_P_W-1] ? {1'b1, {(RATE_W-1){1'b0}}}
                                              : {1'b0, {(RATE_W-1){1'b1}}};
        end else begin
          rate_hold_nxt = mul_prod[55:24];
        end
        if (calib_mode_r) begin
          clean_hold_nxt  = rate_hold_nxt;
          angle_accum_nxt = '0;
          if (calib_count_r != '1) begin
            calib_count_nxt = calib_count_r + 1'b1;
          end
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_DEAD;
        end
      end
      ST_DEAD: begin
        clean_hold_nxt = (rate_abs < {1'b0, dead_band_r}) ? '0 : rate_hold_r;
        state_nxt      = ST_ANG_GO;
      end
      ST_ANG_GO: begin
        mul_start = 1'b1;
        mul_a     = {{(MUL_A_W-RATE_W){clean_hold_r[RATE_W-1]}}, clean_hold_r};
        mul_b     = step_time_r;
        state_nxt = ST_ANG_MUL;
      end
      ST_ANG_MUL: begin
        if (!mul_busy) begin
          state_nxt = ST_ANG_ADD;
        end
      end
      ST_ANG_ADD: begin
        angle_accum_nxt = angle_accum_r + mul_prod[63:16];
        state_nxt       = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_hold_r    <= '0;
      bias_hold_r   <= '0;
      calib_count_r <= '0;
      calib_mode_r  <= 1'b1;
      angle_accum_r <= '0;
      rate_hold_r   <= '0;
      clean_hold_r  <= '0;
      status_r      <= STATUS_OK;
      out_valid_r   <= 1'b0;
    end else begin
      raw_hold_r    <= raw_hold_nxt;
      bias_hold_r   <= bias_hold_nxt;
      calib_count_r <= calib_count_nxt;
      calib_mode_r  <= calib_mode_nxt;
      angle_accum_r <= angle_accum_nxt;
      rate_hold_r   <= rate_hold_nxt;
      clean_hold_r  <= clean_hold_nxt;
      status_r      <= status_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_scale_r <= RATE_SCALE_RST;
      dead_band_r  <= DEAD_BAND_RST;
      step_time_r  <= STEP_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RATE_SCALE: rate_scale_r <= cfg_data;
        CFG_DEAD_BAND:  dead_band_r  <= cfg_data[DB_W-1:0];
        CFG_STEP_TIME:  step_time_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_raw_rate_r    <= raw_hold_r;
      out_rate_r        <= rate_hold_r;
      out_clean_rate_r  <= clean_hold_r;
      out_angle_r       <= angle_accum_r;
      out_bias_r        <= bias_hold_r;
      out_status_r      <= status_r;
      out_calibrating_r <= calib_mode_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_raw_rate    = out_raw_rate_r;
  assign out_rate        = out_rate_r;
  assign out_clean_rate  = out_clean_rate_r;
  assign out_angle       = out_angle_r;
  assign out_bias        = out_bias_r;
  assign out_status      = out_status_r;
  assign out_calibrating = out_calibrating_r;

  // The shared multiplier must be free whenever a new product is started.
  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CAL_GO || state_r == ST_RATE_GO || state_r == ST_ANG_GO) |-> !mul_busy)
    else $error("multiplier started while busy");

  // A command finishes without touching the arithmetic units.
  a_cmd_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_func != FUNC_SAMPLE) |=> state_r == ST_PUSH)
    else $error("command did not go straight to the output stage");

  // The sample count only moves while calibration mode is active.
  a_count_mode: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(calib_count_r) |-> calib_mode_r)
    else $error("calibration count changed outside calibration");

  // A calibration sample leaves the angle at zero.
  a_cal_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RATE_SAT && calib_mode_r) |=> angle_accum_r == '0)
    else $error("angle not cleared by calibration sample");

  // A free output register always takes the finished result.
  a_push_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not moved to the output register");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the gyro rate bias integrator
// Sends sensor samples and commands through a valid/stall channel, with
// random gaps on the sender side and random stalls on the result side.
// A built-in predictor tracks the bias, rate, dead band and angle state and
// every result is checked field by field in order. Configuration registers
// are rewritten between traffic phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import gri_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam int REPORT_MAX  = 10;
  localparam int GAP_MAX     = 17;

  localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
  localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

  localparam longint RATE_HI = 64'sd2147483647;
  localparam longint RATE_LO = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]         func;
    logic [31:0]        word;
    logic               link;
    logic [ANGLE_W-1:0] angle;
    logic [BIAS_W-1:0]  bias;
  } gyro_request_t;

  typedef struct packed {
    logic [RAW_W-1:0]   raw;
    logic [RATE_W-1:0]  rate;
    logic [RATE_W-1:0]  clean;
    logic [ANGLE_W-1:0] angle;
    logic [BIAS_W-1:0]  bias;
    logic [1:0]         status;
    logic               calib;
  } gyro_report_t;

  logic                      clk              = 1'b0;
  logic                      rst_n            = 1'b0;
  logic                      in_valid         = 1'b0;
  logic                      in_stall;
  logic [2:0]                in_func          = FUNC_SAMPLE;
  logic [31:0]               in_response_word = '0;
  logic                      in_link_error    = 1'b0;
  logic signed [ANGLE_W-1:0] in_angle_value   = '0;
  logic signed [BIAS_W-1:0]  in_bias_value    = '0;
  logic                      out_valid;
  logic                      out_stall        = 1'b0;
  logic signed [RAW_W-1:0]   out_raw_rate;
  logic signed [RATE_W-1:0]  out_rate;
  logic signed [RATE_W-1:0]  out_clean_rate;
  logic signed [ANGLE_W-1:0] out_angle;
  logic signed [BIAS_W-1:0]  out_bias;
  logic [1:0]                out_status;
  logic                      out_calibrating;
  logic                      cfg_valid        = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index        = CFG_RATE_SCALE;
  logic [CFG_W-1:0]          cfg_data         = '0;

  gyro_report_t expected_reports[$];
  int           error_count    = 0;
  int           cycle_count    = 0;
  int           items_sent     = 0;
  int           sender_gap_max = GAP_MAX;
  int           sink_stall_max = GAP_MAX;
  int           stall_left     = 0;
  int           raw_center     = 0;

  logic signed [RAW_W-1:0]  held_raw;
  logic signed [BIAS_W-1:0] held_bias;
  logic [CNT_W-1:0]         cal_samples;
  logic                     cal_active;
  logic [ANGLE_W-1:0]       angle_sum;
  logic signed [RATE_W-1:0] held_rate;
  logic signed [RATE_W-1:0] held_clean;
  logic [CFG_W-1:0]         scale_reg;
  logic [DB_W-1:0]          band_reg;
  logic [CFG_W-1:0]         period_reg;

  gyro_rate_bias_integrator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_response_word (in_response_word),
    .in_link_error    (in_link_error),
    .in_angle_value   (in_angle_value),
    .in_bias_value    (in_bias_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_raw_rate     (out_raw_rate),
    .out_rate         (out_rate),
    .out_clean_rate   (out_clean_rate),
    .out_angle        (out_angle),
    .out_bias         (out_bias),
    .out_status       (out_status),
    .out_calibrating  (out_calibrating),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void reset_gyro_model();
    held_raw    = '0;
    held_bias   = '0;
    cal_samples = '0;
    cal_active  = 1'b1;
    angle_sum   = '0;
    held_rate   = '0;
    held_clean  = '0;
    scale_reg   = RATE_SCALE_RST;
    band_reg    = DEAD_BAND_RST;
    period_reg  = STEP_TIME_RST;
  endfunction

  function automatic logic signed [RATE_W-1:0] scaled_rate_now();
    longint diff;
    longint prod;
    diff = longint'(held_raw) * 256 - longint'(held_bias);
    prod = (diff * longint'(scale_reg)) >>> 24;
    if (prod > RATE_HI) prod = RATE_HI;
    if (prod < RATE_LO) prod = RATE_LO;
    return prod[RATE_W-1:0];
  endfunction

  function automatic void advance_gyro_model(gyro_request_t r);
    gyro_report_t rep;
    logic [1:0]   st;
    longint       num;
    longint       step;
    longint       band;
    st = STATUS_OK;
    case (r.func)
      FUNC_SAMPLE: begin
        if (r.link || r.word[31:29] != 3'b000) st = STATUS_LINK;
        else if (r.word[27:26] == 2'b01 && !r.word[2]) held_raw = r.word[25:10];
        else st = STATUS_DEVICE;
        if (!cal_active) begin
          band = longint'(band_reg);
          held_rate = scaled_rate_now();
          if (longint'(held_rate) < band && longint'(held_rate) > -band) held_clean = '0;
          else held_clean = held_rate;
          step = (longint'(held_clean) * longint'(period_reg)) >>> 16;
          angle_sum = angle_sum + step[ANGLE_W-1:0];
        end else if (st == STATUS_OK) begin
          num = longint'(cal_samples) * longint'(held_bias) + longint'(held_raw) * 256;
          held_bias = BIAS_W'(num / (longint'(cal_samples) + 1));
          held_rate = scaled_rate_now();
          held_clean = held_rate;
          angle_sum = '0;
          if (cal_samples != '1) cal_samples = cal_samples + 1'b1;
        end
      end
      FUNC_CAL_START: begin
        cal_active  = 1'b1;
        cal_samples = '0;
        held_bias   = '0;
      end
      FUNC_CAL_STOP:  cal_active = 1'b0;
      FUNC_SET_ANGLE: angle_sum = r.angle;
      FUNC_SET_BIAS:  held_bias = r.bias;
      default: ;
    endcase
    rep.raw    = held_raw;
    rep.rate   = held_rate;
    rep.clean  = held_clean;
    rep.angle  = angle_sum;
    rep.bias   = held_bias;
    rep.status = st;
    rep.calib  = cal_active;
    expected_reports.push_back(rep);
  endfunction

  function automatic gyro_request_t make_request(logic [2:0] func, logic [31:0] word,
                                                 logic link);
    gyro_request_t r;
    r.func  = func;
    r.word  = word;
    r.link  = link;
    r.angle = 48'({$urandom, $urandom});
    r.bias  = 24'($urandom);
    return r;
  endfunction

  function automatic gyro_request_t good_sample(logic [RAW_W-1:0] raw);
    gyro_request_t r;
    r = make_request(FUNC_SAMPLE, $urandom, 1'b0);
    r.word[31:29] = 3'b000;
    r.word[27:26] = 2'b01;
    r.word[25:10] = raw;
    r.word[2]     = 1'b0;
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] random_raw();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return 16'($urandom);
      default: return 16'(raw_center + $urandom_range(0, 400) - 200);
    endcase
  endfunction

  function automatic gyro_request_t faulty_sample();
    gyro_request_t r;
    r = good_sample(random_raw());
    case ($urandom_range(0, 4))
      0: r.link = 1'b1;
      1: r.word[31:29] = 3'($urandom_range(1, 7));
      2: r.word[27:26] = 2'($urandom_range(2, 4));
      3: r.word[2] = 1'b1;
      default: begin
        r.word = $urandom;
        r.link = 1'($urandom_range(0, 1));
      end
    endcase
    return r;
  endfunction

  task automatic send_request(gyro_request_t r);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= r.func;
    in_response_word <= r.word;
    in_link_error    <= r.link;
    in_angle_value   <= r.angle;
    in_bias_value    <= r.bias;
    do @(posedge clk); while (in_stall);
    advance_gyro_model(r);
    items_sent++;
  endtask

  task automatic send_set(logic [2:0] func, logic [ANGLE_W-1:0] value);
    gyro_request_t r;
    r = make_request(func, $urandom, 1'($urandom_range(0, 1)));
    r.angle = value;
    r.bias  = value[BIAS_W-1:0];
    send_request(r);
  endtask

  task automatic send_mixed_sample(int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) send_request(faulty_sample());
    else send_request(good_sample(random_raw()));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic load_registers(logic [31:0] scale, logic [31:0] band, logic [31:0] period);
    logic [1:0]  idx[3];
    logic [31:0] vals[3];
    idx  = '{CFG_RATE_SCALE, CFG_DEAD_BAND, CFG_STEP_TIME};
    vals = '{scale, band, period};
    drain_results();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    scale_reg  = scale;
    band_reg   = band[DB_W-1:0];
    period_reg = period;
  endtask

  task automatic test_calibration_samples();
    gyro_request_t r;
    send_request(good_sample(16'h7FFF));
    send_request(good_sample(16'h8000));
    r = good_sample(16'h0123);
    r.link = 1'b1;
    send_request(r);
    r = good_sample(16'h0123);
    r.word[31] = 1'b1;
    send_request(r);
    r = good_sample(16'h0123);
    r.word[27:26] = 2'b10;
    send_request(r);
    r = good_sample(16'h0123);
    r.word[2] = 1'b1;
    send_request(r);
    send_request(make_request(FUNC_SAMPLE, '1, 1'b1));
  endtask

  task automatic test_commands();
    send_request(make_request(FUNC_CAL_STOP, $urandom, 1'b0));
    send_request(good_sample(16'h0100));
    send_set(FUNC_SET_ANGLE, 48'h7FFF_FFFF_FFFF);
    send_set(FUNC_SET_ANGLE, 48'h8000_0000_0000);
    send_set(FUNC_SET_BIAS, 48'h7F_FFFF);
    send_request(good_sample(16'h0000));
    send_set(FUNC_SET_BIAS, 48'h80_0000);
    send_request(good_sample(16'hFF00));
    for (int f = FUNC_RSVD_FIRST; f <= FUNC_RSVD_LAST; f++) begin
      send_request(make_request(3'(f), $urandom, 1'($urandom_range(0, 1))));
    end
    send_request(make_request(FUNC_CAL_START, $urandom, 1'b1));
  endtask

  task automatic test_register_extremes();
    load_registers('1, '1, '1);
    send_request(make_request(FUNC_CAL_STOP, $urandom, 1'b0));
    send_set(FUNC_SET_BIAS, 48'h80_0000);
    send_request(good_sample(16'h7FFF));
    send_set(FUNC_SET_BIAS, 48'h7F_FFFF);
    send_request(good_sample(16'h8000));
    load_registers('0, '0, '0);
    send_request(good_sample(16'h1234));
  endtask

  task automatic random_phase(int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_request(make_request(FUNC_CAL_START, $urandom, 1'($urandom_range(0, 1))));
          repeat ($urandom_range(1, 24)) send_mixed_sample(12);
          send_request(make_request(FUNC_CAL_STOP, $urandom, 1'($urandom_range(0, 1))));
        end
        2: send_set(FUNC_SET_ANGLE, 48'({$urandom, $urandom}));
        3: send_set(FUNC_SET_BIAS, 48'($urandom));
        4: send_request(make_request(3'($urandom_range(FUNC_SAMPLE, FUNC_RSVD_LAST)),
                                     $urandom, 1'($urandom_range(0, 1))));
        default: repeat ($urandom_range(1, 30)) send_mixed_sample(8);
      endcase
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] scale;
    logic [31:0] band;
    logic [31:0] period;
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0:       scale = '1;
        1:       scale = '0;
        2:       scale = $urandom;
        default: scale = $urandom_range(1, 1 << 22);
      endcase
      case ($urandom_range(0, 4))
        0:       band = '1;
        1:       band = '0;
        default: band = $urandom_range(0, 1 << 14);
      endcase
      case ($urandom_range(0, 3))
        0:       period = '1;
        1:       period = '0;
        2:       period = $urandom;
        default: period = $urandom_range(1, 1 << 24);
      endcase
      if (p == 0) begin
        scale  = RATE_SCALE_RST;
        period = STEP_TIME_RST;
      end
      load_registers(scale, band, period);
      if (p == 3) begin
        sender_gap_max = 0;
        sink_stall_max = 0;
      end else begin
        sender_gap_max = GAP_MAX;
        sink_stall_max = GAP_MAX;
      end
      raw_center = $urandom_range(0, 4000) - 2000;
      random_phase(240);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (out_valid && !out_stall) begin
      stall_left = $urandom_range(0, sink_stall_max);
      out_stall <= (stall_left != 0);
    end else if (out_valid && out_stall) begin
      stall_left = stall_left - 1;
      if (stall_left <= 0) out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    gyro_report_t seen;
    gyro_report_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = {out_raw_rate, out_rate, out_clean_rate, out_angle, out_bias, out_status,
              out_calibrating};
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("Unexpected result at cycle %0d: raw=%h rate=%h clean=%h angle=%h bias=%h",
                   cycle_count, seen.raw, seen.rate, seen.clean, seen.angle, seen.bias);
        end
      end else begin
        want = expected_reports.pop_front();
        if (seen.raw !== want.raw || seen.rate !== want.rate || seen.clean !== want.clean ||
            seen.angle !== want.angle || seen.bias !== want.bias ||
            seen.status !== want.status || seen.calib !== want.calib) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("Mismatch at cycle %0d", cycle_count);
            $display("  expected raw=%h rate=%h clean=%h angle=%h bias=%h status=%0d cal=%0d",
                     want.raw, want.rate, want.clean, want.angle, want.bias, want.status,
                     want.calib);
            $display("  actual   raw=%h rate=%h clean=%h angle=%h bias=%h status=%0d cal=%0d",
                     seen.raw, seen.rate, seen.clean, seen.angle, seen.bias, seen.status,
                     seen.calib);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    reset_gyro_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_calibration_samples();
    test_commands();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
